// ----- hw/rtl/plir_pkg.sv -----
// Package for the positional list insert/remove block.
// Holds the default capacity, operation codes and the sequencer state type.
// No dependencies.
package plir_pkg;

	// Default number of list entries.
	localparam int unsigned CAPACITY_DEF = 16;

	// Width of one list entry.
	localparam int unsigned DATA_W = 32;

	// Width of the position field.
	localparam int unsigned POS_W = 8;

	// Operation codes.
	localparam logic OP_REMOVE = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

// ----- hw/rtl/plir_ram.sv -----
// Single-write, single-read list storage with a registered read port.
// Depends on plir_pkg for default widths.
module plir_ram #(
	parameter int unsigned DEPTH = plir_pkg::CAPACITY_DEF,
	parameter int unsigned WIDTH = plir_pkg::DATA_W,
	parameter int unsigned AW    = $clog2(plir_pkg::CAPACITY_DEF)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data register holds its value until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/positional_list_insert_remove_top.sv -----
// Positional list insert/remove block: top level with the sequencer.
// Depends on plir_pkg and instantiates plir_ram.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in
// a list memory. Each input transaction inserts new_value at position
// (later entries move up) or removes the entry at position (later entries
// move down); afterwards the whole list is sent out in order, one output
// transaction per entry, with is_last on the final one. An empty list gives
// one output transaction with item_value zero and list_empty set. Positions
// out of range, and inserts into a full list, leave the list unchanged and
// clear op_applied. The time for one input transaction is set by the list
// memory, which both the shift and the readout walk one entry per cycle
// through its single read and single write port; the readout holds while
// out_stall keeps the output slot full. in_stall stays high from
// acceptance until the last output transaction is taken.
module positional_list_insert_remove_top #(
	parameter int unsigned CAPACITY = plir_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic signed [plir_pkg::DATA_W-1:0] new_value,
	input  logic        [plir_pkg::POS_W-1:0]  position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [plir_pkg::DATA_W-1:0] item_value,
	output logic                             is_last,
	output logic                             list_empty,
	output logic                             op_applied
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	plir_pkg::state_t state_q, state_d;

	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               pos_q;
	logic [CW-1:0]               moves_q;
	logic [CW-1:0]               emit_q;
	logic                        ins_q;
	logic [plir_pkg::DATA_W-1:0] val_q;
	logic                        wr_pend_q;
	logic [AW-1:0]               wr_addr_q;
	logic                        out_valid_q;
	logic                        is_last_q;
	logic                        empty_q;
	logic                        applied_q;

	logic                        in_acc;
	logic                        is_ins;
	logic [plir_pkg::POS_W-1:0]  cnt_ext;
	logic                        ins_ok;
	logic                        rem_ok;
	logic                        acc_applied;
	logic [CW-1:0]               shift_rd;
	logic [CW-1:0]               shift_wr;
	logic [CW-1:0]               emit_total;
	logic                        slot_free;
	logic                        emit_load;

	logic                        ram_wr_en;
	logic [AW-1:0]               ram_wr_addr;
	logic [plir_pkg::DATA_W-1:0] ram_wr_data;
	logic                        ram_rd_en;
	logic [AW-1:0]               ram_rd_addr;
	logic [plir_pkg::DATA_W-1:0] ram_rd_data;

	// Input handshake and range checks on the incoming transaction.
	assign in_stall = (state_q != plir_pkg::ST_IDLE) || out_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign is_ins   = (operation == plir_pkg::OP_INSERT);
	assign cnt_ext  = plir_pkg::POS_W'(cnt_q);
	assign ins_ok   = (cnt_q < CW'(CAPACITY)) && (position <= cnt_ext);
	assign rem_ok   = (position < cnt_ext);
	assign acc_applied = is_ins ? ins_ok : rem_ok;

	// Shift addresses: inserts walk downward, removes walk upward.
	always_comb begin
		if (ins_q) begin
			shift_rd = pos_q + moves_q - CW'(1);
			shift_wr = shift_rd + CW'(1);
		end else begin
			shift_rd = cnt_q + CW'(1) - moves_q;
			shift_wr = shift_rd - CW'(1);
		end
	end

	// Readout bookkeeping: an empty list still sends one transaction.
	assign emit_total = (cnt_q == '0) ? CW'(1) : cnt_q;
	assign slot_free  = !out_valid_q || !out_stall;
	assign emit_load  = (state_q == plir_pkg::ST_EMIT) && slot_free && (emit_q < emit_total);

	// Memory port control.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wr_addr_q;
		ram_wr_data = ram_rd_data;
		unique case (state_q)
			plir_pkg::ST_SHIFT: begin
				ram_wr_en = wr_pend_q;
				if (moves_q != '0) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = AW'(shift_rd);
				end
			end
			plir_pkg::ST_FINAL: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = AW'(pos_q);
				ram_wr_data = val_q;
			end
			plir_pkg::ST_EMIT: begin
				ram_rd_en   = emit_load;
				ram_rd_addr = AW'(emit_q);
			end
			default: begin
			end
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plir_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = acc_applied ? plir_pkg::ST_SHIFT : plir_pkg::ST_EMIT;
				end
			end
			plir_pkg::ST_SHIFT: begin
				if (moves_q == '0 && !wr_pend_q) begin
					state_d = ins_q ? plir_pkg::ST_FINAL : plir_pkg::ST_EMIT;
				end
			end
			plir_pkg::ST_FINAL: begin
				state_d = plir_pkg::ST_EMIT;
			end
			plir_pkg::ST_EMIT: begin
				if (slot_free && !(emit_q < emit_total)) begin
					state_d = plir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plir_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plir_pkg::ST_IDLE;
			cnt_q       <= '0;
			moves_q     <= '0;
			emit_q      <= '0;
			wr_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				emit_q <= '0;
				if (is_ins && ins_ok) begin
					cnt_q   <= cnt_q + CW'(1);
					moves_q <= cnt_q - CW'(position);
				end else if (!is_ins && rem_ok) begin
					cnt_q   <= cnt_q - CW'(1);
					moves_q <= cnt_q - CW'(1) - CW'(position);
				end else begin
					moves_q <= '0;
				end
			end
			// One entry moves per cycle while shifting.
			if (state_q == plir_pkg::ST_SHIFT) begin
				wr_pend_q <= (moves_q != '0);
				if (moves_q != '0) begin
					moves_q <= moves_q - CW'(1);
				end
			end else begin
				wr_pend_q <= 1'b0;
			end
			// Output slot: load a new entry or drop valid once taken.
			if (emit_load) begin
				out_valid_q <= 1'b1;
				emit_q      <= emit_q + CW'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_q     <= is_ins;
			val_q     <= new_value;
			pos_q     <= CW'(position);
			applied_q <= acc_applied;
		end
		if (state_q == plir_pkg::ST_SHIFT && moves_q != '0) begin
			wr_addr_q <= AW'(shift_wr);
		end
		if (emit_load) begin
			is_last_q <= (emit_q + CW'(1) == emit_total);
			empty_q   <= (cnt_q == '0);
		end
	end

	plir_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (plir_pkg::DATA_W),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Output ports.
	assign out_valid  = out_valid_q;
	assign item_value = empty_q ? '0 : $signed(ram_rd_data);
	assign is_last    = is_last_q;
	assign list_empty = empty_q;
	assign op_applied = applied_q;

	// The output slot is never loaded while the memory is being shifted.
	a_no_out_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plir_pkg::ST_SHIFT || state_q == plir_pkg::ST_FINAL) |-> !out_valid_q)
		else $error("output valid while shifting the list");

	// The entry count never exceeds the capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An empty-list transaction is always the last of its item.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> is_last_q)
		else $error("empty list result not marked last");

	// An accepted input transaction blocks further input on the next cycle.
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after acceptance");

endmodule
